>>> sv/fsfr_pkg.sv
// Package for the flow sensor frame receiver: parser states, frame constants,
// the queue entry type and the CRC8 byte update. No dependencies.
package fsfr_pkg;

   localparam logic [7:0] HDR_FIRST = 8'hFA;
   localparam logic [7:0] HDR_SECOND = 8'hAA;
   localparam logic [7:0] CRC_POLY = 8'hD5;
   localparam int DATA_LEN = 14;
   localparam int BODY_LEN = DATA_LEN + 1;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      ST_WAIT1 = 2'd0,
      ST_WAIT2 = 2'd1,
      ST_BODY  = 2'd2
   } sync_state_type;

   typedef struct packed {
      logic                          is_clear;
      logic                          crc_ok;
      logic [DATA_LEN-1:0][7:0]      bytes;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

>>> sv/flow_sensor_frame_receiver.sv
// Top level of the flow sensor frame receiver: front end, entry queue, back end.
// Depends on fsfr_pkg, fsfr_front, fsfr_queue and fsfr_back.

// The receiver takes one serial byte per cycle and hunts for 17-byte frames
// that open with 0xFA 0xAA, checking CRC8 (polynomial 0xD5, init 0) over the
// fourteen data bytes against the last byte. A clear command (tuser high)
// resets the lost-frame total and sequence history without moving the parser.
// Each completed frame gives one result transaction, through the entry queue
// and the result register, with frame_ok in tuser; a failed frame carries
// zero data fields and the unchanged lost total. Input is held off only while
// the entry queue between the parser and the result register is full, which
// happens only when the result side stalls, else one byte goes in per cycle.
module flow_sensor_frame_receiver #(
   parameter int QUEUE_DEPTH = fsfr_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // [7:0] data_byte
   input  logic         req_tuser,  // [0] cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] flow_x, [31:16] flow_y, [47:32] rotation, [71:48] height,
   // [79:72] quality, [87:80] lux, [95:88] dt_flow, [103:96] height_period,
   // [111:104] sequence_res, [119:112] lost_in_frame, [151:120] lost_total
   output logic [151:0] rsp_tdata,
   output logic         rsp_tuser   // [0] frame_ok
);

   fsfr_pkg::push_type push;
   fsfr_pkg::entry_type pop_entry;
   logic full, pop_valid, pop_ready;

   assign req_tready = !full;

   fsfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_tvalid && req_tready),
      .cmd       (req_tuser),
      .data_byte (req_tdata),
      .push      (push)
   );

   fsfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry)
   );

   fsfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> sv/fsfr_front.sv
// Front end of the frame receiver: header sync, body collection and running CRC.
// Pushes one entry per clear command or completed frame. Depends on fsfr_pkg.
module fsfr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               cmd,
   input  logic [7:0]         data_byte,
   output fsfr_pkg::push_type push
);

   localparam int CNT_W = $clog2(fsfr_pkg::BODY_LEN);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(fsfr_pkg::BODY_LEN - 1);

   fsfr_pkg::sync_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0] crc_ff, crc_in;
   logic [fsfr_pkg::DATA_LEN-1:0][7:0] bytes_ff, bytes_in;

   always_comb begin
      state_in = state_ff;
      if (accept && !cmd) begin
         unique case (state_ff)
            fsfr_pkg::ST_WAIT1: begin
               if (data_byte == fsfr_pkg::HDR_FIRST) state_in = fsfr_pkg::ST_WAIT2;
            end
            fsfr_pkg::ST_WAIT2: begin
               if (data_byte == fsfr_pkg::HDR_SECOND) begin
                  state_in = fsfr_pkg::ST_BODY;
               end else if (data_byte != fsfr_pkg::HDR_FIRST) begin
                  state_in = fsfr_pkg::ST_WAIT1;
               end
            end
            fsfr_pkg::ST_BODY: begin
               if (count_ff == LAST_CNT) state_in = fsfr_pkg::ST_WAIT1;
            end
            default: state_in = fsfr_pkg::ST_WAIT1;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      crc_in = crc_ff;
      bytes_in = bytes_ff;
      push.valid = 1'b0;
      push.entry.is_clear = cmd;
      push.entry.crc_ok = (crc_ff == data_byte);
      push.entry.bytes = bytes_ff;
      if (accept) begin
         if (cmd) begin
            push.valid = 1'b1;
         end else begin
            unique case (state_ff)
               fsfr_pkg::ST_WAIT1: ;
               fsfr_pkg::ST_WAIT2: begin
                  count_in = '0;
                  crc_in = '0;
               end
               fsfr_pkg::ST_BODY: begin
                  if (count_ff == LAST_CNT) begin
                     push.valid = 1'b1;
                     count_in = '0;
                  end else begin
                     bytes_in = {data_byte, bytes_ff[fsfr_pkg::DATA_LEN-1:1]};
                     crc_in = fsfr_pkg::crc_byte(crc_ff, data_byte);
                     count_in = count_ff + 1'b1;
                  end
               end
               default: count_in = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsfr_pkg::ST_WAIT1;
         count_ff <= '0;
         crc_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         crc_ff <= crc_in;
      end
      bytes_ff <= bytes_in;
   end

endmodule

>>> sv/fsfr_queue.sv
// Short first-in first-out queue of parsed entries between front and back end.
// Depends on fsfr_pkg for the entry type.
module fsfr_queue #(
   parameter int DEPTH = fsfr_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  fsfr_pkg::push_type  push,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop_ready,
   output fsfr_pkg::entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   fsfr_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slots_ff[rd_ptr_ff];
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push.valid) slots_ff[wr_ptr_ff] <= push.entry;
   end

endmodule

>>> sv/fsfr_back.sv
// Back end of the frame receiver: sequence gap tracking, lost frame total and
// the result output register. Depends on fsfr_pkg.
module fsfr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  fsfr_pkg::entry_type pop_entry,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [151:0]        rsp_tdata,
   output logic                rsp_tuser
);

   logic out_valid_ff, out_valid_in;
   logic [151:0] out_data_ff, out_data_in;
   logic out_ok_ff, out_ok_in;
   logic [7:0] last_seq_ff, last_seq_in;
   logic seq_valid_ff, seq_valid_in;
   logic [31:0] total_ff, total_in;
   logic [7:0] seq, lost;
   logic [31:0] new_total;
   logic take;
   logic [fsfr_pkg::DATA_LEN-1:0][7:0] b;

   assign b = pop_entry.bytes;
   assign seq = b[13];
   assign lost = seq_valid_ff ? (seq - (last_seq_ff + 8'd1)) : 8'd0;
   assign new_total = total_ff + {24'd0, lost};
   assign pop_ready = pop_entry.is_clear || !out_valid_ff || rsp_tready;
   assign take = pop_valid && pop_ready;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_ok_in = out_ok_ff;
      last_seq_in = last_seq_ff;
      seq_valid_in = seq_valid_ff;
      total_in = total_ff;
      if (take) begin
         if (pop_entry.is_clear) begin
            total_in = '0;
            last_seq_in = 8'hFF;
            seq_valid_in = 1'b0;
         end else if (pop_entry.crc_ok) begin
            out_valid_in = 1'b1;
            out_ok_in = 1'b1;
            out_data_in = {new_total, lost, seq, b[12], b[11], b[10], b[9],
                           b[6], b[7], b[8], b[4], b[5], b[2], b[3], b[0], b[1]};
            total_in = new_total;
            last_seq_in = seq;
            seq_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b1;
            out_ok_in = 1'b0;
            out_data_in = {total_ff, 120'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         last_seq_ff <= 8'hFF;
         seq_valid_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         last_seq_ff <= last_seq_in;
         seq_valid_ff <= seq_valid_in;
         total_ff <= total_in;
      end
      out_data_ff <= out_data_in;
      out_ok_ff <= out_ok_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_ok_ff;

endmodule

>>> tb/fsfr_tb_pkg.sv
// Shared helpers for the flow sensor frame receiver testbench: the CRC8 byte
// update used both to build frames and to predict results. No dependencies.
`timescale 1ns / 1ps
package fsfr_tb_pkg;

   localparam logic [7:0] DVB_S2_POLY = 8'hD5;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] value);
      logic [7:0] acc;
      acc = crc ^ value;
      repeat (8) begin
         acc = acc[7] ? ({acc[6:0], 1'b0} ^ DVB_S2_POLY) : {acc[6:0], 1'b0};
      end
      return acc;
   endfunction

endpackage

>>> tb/fsfr_checker.sv
// Checker for the flow sensor frame receiver: watches both streams, predicts each
// frame result and compares it field by field. Depends on fsfr_pkg and fsfr_tb_pkg.
`timescale 1ns / 1ps
module fsfr_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [151:0] rsp_tdata,
   input  logic         rsp_tuser,
   output int           failures,
   output int           pending,
   output int           good_frames,
   output int           bad_frames
);
   import fsfr_pkg::*;
   import fsfr_tb_pkg::*;

   // Field order matches {rsp_tuser, rsp_tdata}.
   typedef struct packed {
      logic               frame_ok;
      logic [31:0]        lost_total;
      logic [7:0]         lost_in_frame;
      logic [7:0]         sequence_res;
      logic [7:0]         height_period;
      logic [7:0]         dt_flow;
      logic [7:0]         lux;
      logic [7:0]         quality;
      logic [23:0]        height;
      logic signed [15:0] rotation;
      logic signed [15:0] flow_y;
      logic signed [15:0] flow_x;
   } flow_result_t;

   flow_result_t   frames_due[$];
   sync_state_type parse_state;
   int             body_count;
   logic [7:0]     body_bytes [0:BODY_LEN-1];
   logic [7:0]     prev_seq;
   bit             seq_known;
   logic [31:0]    lost_sum;

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   function automatic flow_result_t frame_result();
      flow_result_t res;
      logic [7:0]   crc;
      logic [7:0]   lost;
      res = '0;
      crc = 8'h00;
      for (int i = 0; i < DATA_LEN; i++) crc = crc8_step(crc, body_bytes[i]);
      if (crc == body_bytes[DATA_LEN]) begin
         lost = seq_known ? body_bytes[DATA_LEN-1] - (prev_seq + 8'd1) : 8'd0;
         lost_sum += lost;
         prev_seq = body_bytes[DATA_LEN-1];
         seq_known = 1'b1;
         res.frame_ok = 1'b1;
         res.flow_x = {body_bytes[0], body_bytes[1]};
         res.flow_y = {body_bytes[2], body_bytes[3]};
         res.rotation = {body_bytes[4], body_bytes[5]};
         res.height = {body_bytes[6], body_bytes[7], body_bytes[8]};
         res.quality = body_bytes[9];
         res.lux = body_bytes[10];
         res.dt_flow = body_bytes[11];
         res.height_period = body_bytes[12];
         res.sequence_res = body_bytes[13];
         res.lost_in_frame = lost;
      end
      res.lost_total = lost_sum;
      return res;
   endfunction

   always @(posedge clock) begin
      flow_result_t want;
      flow_result_t got;
      if (reset) begin
         frames_due.delete();
         parse_state = ST_WAIT1;
         body_count = 0;
         prev_seq = 8'hFF;
         seq_known = 1'b0;
         lost_sum = '0;
         failures = 0;
         good_frames = 0;
         bad_frames = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               lost_sum = '0;
               prev_seq = 8'hFF;
               seq_known = 1'b0;
            end else begin
               case (parse_state)
                  ST_WAIT1: begin
                     if (req_tdata == HDR_FIRST) parse_state = ST_WAIT2;
                  end
                  ST_WAIT2: begin
                     if (req_tdata == HDR_SECOND) begin
                        body_count = 0;
                        parse_state = ST_BODY;
                     end else if (req_tdata != HDR_FIRST) begin
                        parse_state = ST_WAIT1;
                     end
                  end
                  ST_BODY: begin
                     body_bytes[body_count] = req_tdata;
                     body_count++;
                     if (body_count == BODY_LEN) begin
                        body_count = 0;
                        parse_state = ST_WAIT1;
                        frames_due.push_back(frame_result());
                     end
                  end
                  default: begin
                     parse_state = ST_WAIT1;
                     body_count = 0;
                  end
               endcase
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (frames_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0h", $time, got);
               failures++;
            end else begin
               want = frames_due.pop_front();
               check_field("frame_ok", want.frame_ok, got.frame_ok);
               check_field("flow_x", want.flow_x, got.flow_x);
               check_field("flow_y", want.flow_y, got.flow_y);
               check_field("rotation", want.rotation, got.rotation);
               check_field("height", want.height, got.height);
               check_field("quality", want.quality, got.quality);
               check_field("lux", want.lux, got.lux);
               check_field("dt_flow", want.dt_flow, got.dt_flow);
               check_field("height_period", want.height_period, got.height_period);
               check_field("sequence_res", want.sequence_res, got.sequence_res);
               check_field("lost_in_frame", want.lost_in_frame, got.lost_in_frame);
               check_field("lost_total", want.lost_total, got.lost_total);
               if (want.frame_ok) good_frames++;
               else bad_frames++;
            end
         end
      end
      pending = frames_due.size();
   end

endmodule

>>> tb/tb_top.sv
// Top of the flow sensor frame receiver testbench: clock, reset, byte stimulus
// and result back-pressure. Depends on fsfr_pkg, fsfr_tb_pkg, fsfr_checker and the DUT.
`timescale 1ns / 1ps
module tb_top;
   import fsfr_pkg::*;
   import fsfr_tb_pkg::*;

   localparam int ITEM_TARGET = 900;
   localparam int IDLE_LIMIT = 1000;
   localparam int TAIL_CYCLES = 16;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;
   logic         rsp_tuser;

   int failures;
   int pending;
   int good_frames;
   int bad_frames;

   int         sent_items = 0;
   int         noise_items = 0;
   int         clears_sent = 0;
   int         send_mode_left = 0;
   bit         send_quiet = 1'b0;
   int         recv_mode_left = 0;
   bit         recv_quiet = 1'b0;
   int         rsp_stall = 0;
   int         idle_cycles = 0;
   logic [7:0] tx_seq = 8'hFF;

   flow_sensor_frame_receiver dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   fsfr_checker chk (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .failures(failures),
      .pending(pending),
      .good_frames(good_frames),
      .bad_frames(bad_frames)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("Timeout after %0d cycles without a transaction", IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      int stall_draw;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (recv_mode_left == 0) begin
            recv_quiet = ($urandom_range(0, 3) == 0);
            recv_mode_left = $urandom_range(10, 40);
         end
         recv_mode_left--;
         stall_draw = recv_quiet ? 0 : $urandom_range(0, 8);
         rsp_stall <= stall_draw;
         rsp_tready <= (stall_draw == 0);
      end else if (rsp_stall > 1) begin
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_stall <= 0;
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_item(input logic cmd, input logic [7:0] value);
      int gap;
      if (send_mode_left == 0) begin
         send_quiet = ($urandom_range(0, 3) == 0);
         send_mode_left = $urandom_range(20, 80);
      end
      send_mode_left--;
      gap = send_quiet ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tuser <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
      if (cmd) clears_sent++;
   endtask

   // Sends the fourteen data bytes and a CRC byte, optionally spoiled, with a
   // clear command slipped in before body byte clear_at when it is not negative.
   task automatic send_body(input logic [7:0] data [0:DATA_LEN-1], input bit corrupt,
                            input int clear_at);
      logic [7:0] crc;
      logic [7:0] crc_tx;
      crc = 8'h00;
      for (int i = 0; i < DATA_LEN; i++) crc = crc8_step(crc, data[i]);
      crc_tx = corrupt ? crc ^ 8'($urandom_range(1, 255)) : crc;
      for (int i = 0; i < BODY_LEN; i++) begin
         if (i == clear_at) send_item(1'b1, 8'($urandom_range(0, 255)));
         send_item(1'b0, (i < DATA_LEN) ? data[i] : crc_tx);
      end
   endtask

   task automatic send_random_frame();
      logic [7:0] data [0:DATA_LEN-1];
      int         clear_at;
      bit         corrupt;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) send_item(1'b0, HDR_FIRST);
      send_item(1'b0, HDR_FIRST);
      send_item(1'b0, HDR_SECOND);
      for (int i = 0; i < DATA_LEN - 1; i++) data[i] = pick_byte();
      case ($urandom_range(0, 9))
         7: data[DATA_LEN-1] = tx_seq + 8'($urandom_range(2, 255));
         8: data[DATA_LEN-1] = 8'hFF;
         9: data[DATA_LEN-1] = 8'($urandom_range(0, 255));
         default: data[DATA_LEN-1] = tx_seq + 8'd1;
      endcase
      tx_seq = data[DATA_LEN-1];
      corrupt = ($urandom_range(0, 7) == 0);
      clear_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, BODY_LEN - 1) : -1;
      send_body(data, corrupt, clear_at);
   endtask

   initial begin
      logic [7:0] data [0:DATA_LEN-1];
      int         burst;
      wait (!reset);
      @(posedge clock);

      // A stray byte, a wrong second header byte, then a repeated first header byte
      // ahead of a frame with extreme field values and sequence 255 on the first frame.
      send_item(1'b0, 8'h00);
      send_item(1'b0, HDR_FIRST);
      send_item(1'b0, 8'h55);
      send_item(1'b0, HDR_FIRST);
      send_item(1'b0, HDR_FIRST);
      send_item(1'b0, HDR_SECOND);
      data = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF};
      send_body(data, 1'b0, 5);
      tx_seq = 8'hFF;

      while (sent_items - noise_items < ITEM_TARGET) begin
         case ($urandom_range(0, 19))
            0, 1: begin
               burst = $urandom_range(1, 6);
               repeat (burst) begin
                  send_item(1'b0, ($urandom_range(0, 3) == 0) ? HDR_FIRST : pick_byte());
               end
               noise_items += burst;
            end
            2: begin
               send_item(1'b0, HDR_FIRST);
               if ($urandom_range(0, 1) == 0) send_item(1'b0, HDR_FIRST);
               send_item(1'b0, 8'($urandom_range(0, 169)));
            end
            3: send_item(1'b1, 8'($urandom_range(0, 255)));
            default: send_random_frame();
         endcase
      end
      req_tvalid <= 1'b0;

      wait (pending == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run drove %0d input transactions, %0d of them clear commands and %0d noise bytes.",
               sent_items, clears_sent, noise_items);
      $display("Checked %0d frames with a good CRC and %0d with a bad CRC.",
               good_frames, bad_frames);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
